>>> hdl/crc8wfr_pkg.sv
// Shared types, constants and the CRC-8 byte update for the word frame receiver.
// No dependencies; the datapath, controller and top level import this package.
package crc8wfr_pkg;

    localparam logic [7:0] CRC_POLY = 8'h07;

    localparam logic [7:0] HDR1_RST = 8'hFF;
    localparam logic [7:0] HDR2_RST = 8'hFC;
    localparam logic [7:0] TRL1_RST = 8'hA1;
    localparam logic [7:0] TRL2_RST = 8'hA2;

    // Configuration register indexes (byte address bits [3:2])
    localparam logic [1:0] REG_HDR1 = 2'd0;
    localparam logic [1:0] REG_HDR2 = 2'd1;
    localparam logic [1:0] REG_TRL1 = 2'd2;
    localparam logic [1:0] REG_TRL2 = 2'd3;

    typedef struct packed {
        logic [7:0] hdr1;
        logic [7:0] hdr2;
        logic [7:0] trl1;
        logic [7:0] trl2;
    } crc8wfr_cfg_t;

    typedef struct packed {
        logic start;       // header complete: clear count and CRC
        logic take_byte;   // store payload byte, update CRC
        logic take_check;  // capture received check byte
        logic clr_idx;     // frame good: rewind word index
        logic rd_word;     // read word at current index
        logic next_word;   // advance word index
    } crc8wfr_cmd_t;

    typedef struct packed {
        logic hdr1_hit;
        logic hdr2_hit;
        logic trl1_hit;
        logic trl2_hit;
        logic payload_done;
        logic crc_ok;
        logic last;
    } crc8wfr_sts_t;

    typedef enum logic [6:0] {
        ST_HUNT  = 7'b0000001,
        ST_HEAD1 = 7'b0000010,
        ST_DATA  = 7'b0000100,
        ST_TRL1  = 7'b0001000,
        ST_TRL2  = 7'b0010000,
        ST_RD    = 7'b0100000,
        ST_OUT   = 7'b1000000
    } crc8wfr_state_t;

    // MSB-first CRC-8 over one byte, no reflection
    function automatic logic [7:0] crc8_next(input logic [7:0] crc, input logic [7:0] b);
        logic [7:0] v;
        v = crc ^ b;
        for (int k = 0; k < 8; k++) begin
            v = v[7] ? ({v[6:0], 1'b0} ^ CRC_POLY) : {v[6:0], 1'b0};
        end
        return v;
    endfunction

endpackage

>>> hdl/crc8wfr_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module crc8wfr_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

>>> hdl/crc8wfr_dp.sv
// Datapath: byte compares, payload word assembly and storage, CRC, word index.
// Depends on crc8wfr_pkg and crc8wfr_ram.
module crc8wfr_dp #(
    parameter int WORDS = 3
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic [7:0]                 rx_byte,
    input  crc8wfr_pkg::crc8wfr_cfg_t  cfg,
    input  crc8wfr_pkg::crc8wfr_cmd_t  cmd,
    output crc8wfr_pkg::crc8wfr_sts_t  sts,
    output logic signed [31:0]         word_value,
    output logic [3:0]                 word_index
);
    import crc8wfr_pkg::*;

    localparam int PAYLOAD = 4 * WORDS;
    localparam int CW      = $clog2(PAYLOAD + 1);
    localparam int AW      = (WORDS > 1) ? $clog2(WORDS) : 1;

    logic [CW-1:0] count_reg, count_next;
    logic [7:0]    crc_reg, crc_next;
    logic [3:0]    idx_reg, idx_next;
    logic [7:0]    check_reg;
    logic [23:0]   asm_reg;
    logic          wr_en;
    logic [31:0]   wr_data;
    logic [31:0]   rd_data;

    always_comb
    begin
        count_next = count_reg;
        crc_next   = crc_reg;
        idx_next   = idx_reg;
        if (cmd.start)
        begin
            count_next = '0;
            crc_next   = '0;
        end
        else if (cmd.take_byte)
        begin
            count_next = count_reg + CW'(1);
            crc_next   = crc8_next(crc_reg, rx_byte);
        end
        if (cmd.clr_idx)
        begin
            idx_next = '0;
        end
        else if (cmd.next_word)
        begin
            idx_next = idx_reg + 4'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            crc_reg   <= '0;
            idx_reg   <= '0;
        end
        else
        begin
            count_reg <= count_next;
            crc_reg   <= crc_next;
            idx_reg   <= idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.take_byte)
        begin
            asm_reg <= {rx_byte, asm_reg[23:8]};
        end
        if (cmd.take_check)
        begin
            check_reg <= rx_byte;
        end
    end

    // Fourth byte of a word completes it: write little-endian word
    assign wr_en   = cmd.take_byte && (count_reg[1:0] == 2'd3);
    assign wr_data = {rx_byte, asm_reg};

    crc8wfr_ram #(
        .WIDTH (32),
        .DEPTH (WORDS)
    ) u_store (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (count_reg[AW+1:2]),
        .wr_data (wr_data),
        .rd_en   (cmd.rd_word),
        .rd_addr (idx_reg[AW-1:0]),
        .rd_data (rd_data)
    );

    assign sts.hdr1_hit     = (rx_byte == cfg.hdr1);
    assign sts.hdr2_hit     = (rx_byte == cfg.hdr2);
    assign sts.trl1_hit     = (rx_byte == cfg.trl1);
    assign sts.trl2_hit     = (rx_byte == cfg.trl2);
    assign sts.payload_done = (count_reg == CW'(PAYLOAD));
    assign sts.crc_ok       = (check_reg == crc_reg);
    assign sts.last         = (idx_reg == 4'(WORDS - 1));

    assign word_value = $signed(rd_data);
    assign word_index = idx_reg;

endmodule

>>> hdl/crc8wfr_ctrl.sv
// Controller: frame state machine, input and output handshakes, datapath commands.
// Depends on crc8wfr_pkg.
module crc8wfr_ctrl (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       rx_valid,
    input  logic                       word_stall,
    input  crc8wfr_pkg::crc8wfr_sts_t  sts,
    output logic                       rx_stall,
    output logic                       word_valid,
    output crc8wfr_pkg::crc8wfr_cmd_t  cmd
);
    import crc8wfr_pkg::*;

    crc8wfr_state_t state_reg, state_next;
    logic           rx_take;

    assign rx_stall   = (state_reg == ST_RD) || (state_reg == ST_OUT);
    assign word_valid = (state_reg == ST_OUT);
    assign rx_take    = rx_valid && !rx_stall;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_HUNT:
            begin
                if (rx_take && sts.hdr1_hit)
                begin
                    state_next = ST_HEAD1;
                end
            end
            ST_HEAD1:
            begin
                if (rx_take)
                begin
                    if (sts.hdr2_hit)
                    begin
                        state_next = ST_DATA;
                        cmd.start  = 1'b1;
                    end
                    else
                    begin
                        state_next = ST_HUNT;
                    end
                end
            end
            ST_DATA:
            begin
                if (rx_take)
                begin
                    if (sts.payload_done)
                    begin
                        cmd.take_check = 1'b1;
                        state_next     = ST_TRL1;
                    end
                    else
                    begin
                        cmd.take_byte = 1'b1;
                    end
                end
            end
            ST_TRL1:
            begin
                if (rx_take)
                begin
                    state_next = sts.trl1_hit ? ST_TRL2 : ST_HUNT;
                end
            end
            ST_TRL2:
            begin
                if (rx_take)
                begin
                    // bad CRC or wrong trailer: drop frame
                    if (sts.trl2_hit && sts.crc_ok)
                    begin
                        cmd.clr_idx = 1'b1;
                        state_next  = ST_RD;
                    end
                    else
                    begin
                        state_next = ST_HUNT;
                    end
                end
            end
            ST_RD:
            begin
                cmd.rd_word = 1'b1;
                state_next  = ST_OUT;
            end
            ST_OUT:
            begin
                if (!word_stall)
                begin
                    if (sts.last)
                    begin
                        state_next = ST_HUNT;
                    end
                    else
                    begin
                        cmd.next_word = 1'b1;
                        state_next    = ST_RD;
                    end
                end
            end
            default:
            begin
                state_next = ST_HUNT;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_HUNT;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    a_no_rx_while_emit: assert property (@(posedge clk) disable iff (!rst_n)
        word_valid |-> rx_stall)
        else $error("input accepted while a word is presented");

    a_read_then_show: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.rd_word |=> word_valid)
        else $error("word read not followed by output transaction");

    a_advance_reads: assert property (@(posedge clk) disable iff (!rst_n)
        (word_valid && !word_stall && !sts.last) |=> cmd.rd_word)
        else $error("next word not read after transaction");

    a_store_bounds: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.take_byte |-> !sts.payload_done)
        else $error("payload byte stored past end of frame");

endmodule

>>> hdl/crc8_word_frame_receiver.sv
// Word frame receiver top level: configuration registers and APB port,
// controller and datapath. Depends on crc8wfr_pkg, crc8wfr_ctrl, crc8wfr_dp.
//
// Usage: feed received serial bytes on rx_byte with rx_valid; a transaction
// completes on a clock edge with rx_valid high and rx_stall low. The block
// hunts for the header bytes, takes 4*WORDS payload bytes and one CRC-8 byte
// (poly 0x07, init 0), then the two trailer bytes. A wrong header or trailer
// byte returns it to hunting. A frame whose CRC matches leaves as WORDS
// signed little-endian words on word_value/word_index/last_word, one output
// transaction each; a bad CRC drops the frame.
// Throughput: one byte per cycle while receiving. After the final trailer
// byte each word in turn is read from payload memory (ST_RD), then shown
// (ST_OUT). rx_stall is high while words are emitted, and word_stall holds
// the current word and the whole block in place. Reset returns the header
// and trailer registers to FF FC / A1 A2 and the block to hunting.
// Registers sit at byte address 4*i.
module crc8_word_frame_receiver #(
    parameter int WORDS = 3
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [3:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    input  logic               rx_valid,
    output logic               rx_stall,
    input  logic [7:0]         rx_byte,
    output logic               word_valid,
    input  logic               word_stall,
    output logic signed [31:0] word_value,
    output logic [3:0]         word_index,
    output logic               last_word
);
    import crc8wfr_pkg::*;

    crc8wfr_cfg_t cfg_reg, cfg_next;
    crc8wfr_cmd_t cmd;
    crc8wfr_sts_t sts;
    logic         cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_wr)
        begin
            unique case (paddr[3:2])
                REG_HDR1: cfg_next.hdr1 = pwdata[7:0];
                REG_HDR2: cfg_next.hdr2 = pwdata[7:0];
                REG_TRL1: cfg_next.trl1 = pwdata[7:0];
                REG_TRL2: cfg_next.trl2 = pwdata[7:0];
                default:  cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.hdr1 <= HDR1_RST;
            cfg_reg.hdr2 <= HDR2_RST;
            cfg_reg.trl1 <= TRL1_RST;
            cfg_reg.trl2 <= TRL2_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    always_comb
    begin
        unique case (paddr[3:2])
            REG_HDR1: prdata = {24'd0, cfg_reg.hdr1};
            REG_HDR2: prdata = {24'd0, cfg_reg.hdr2};
            REG_TRL1: prdata = {24'd0, cfg_reg.trl1};
            REG_TRL2: prdata = {24'd0, cfg_reg.trl2};
            default:  prdata = '0;
        endcase
    end

    crc8wfr_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .rx_valid   (rx_valid),
        .word_stall (word_stall),
        .sts        (sts),
        .rx_stall   (rx_stall),
        .word_valid (word_valid),
        .cmd        (cmd)
    );

    crc8wfr_dp #(
        .WORDS (WORDS)
    ) u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .rx_byte    (rx_byte),
        .cfg        (cfg_reg),
        .cmd        (cmd),
        .sts        (sts),
        .word_value (word_value),
        .word_index (word_index)
    );

    assign last_word = sts.last;

endmodule
